>>> rtl/srd_pkg.sv
// Shared types and constants for the radial dead-zone stick block.
`timescale 1ns / 1ps
`default_nettype none

package srd_pkg;

    localparam int AXIS_W     = 16;
    localparam int PULL_W     = 8;
    localparam int PULL_OUT_W = 15;
    localparam int DZ_W       = 15;
    localparam int SQ_W       = 32;
    localparam int ROOT_W     = 16;
    localparam int PROD_W     = 30;
    localparam int DEN_W      = 31;
    localparam int IN_W       = 80;
    localparam int OUT_W      = 96;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic [DZ_W-1:0]   STICK_MAX = 15'd32767;
    localparam logic [PULL_W-1:0] PULL_MAX  = 8'd255;

    localparam logic [DZ_W-1:0]   LEFT_DZ_RESET  = 15'd7849;
    localparam logic [DZ_W-1:0]   RIGHT_DZ_RESET = 15'd8689;
    localparam logic [PULL_W-1:0] THRESH_RESET   = 8'd30;

    typedef enum logic [1:0] {
        REG_LEFT_DZ  = 2'd0,
        REG_RIGHT_DZ = 2'd1,
        REG_THRESH   = 2'd2,
        REG_NONE     = 2'd3
    } reg_index_t;

    // Data that rides alongside the root extraction.
    typedef struct packed {
        logic [3:0]              neg;
        logic [3:0][AXIS_W-1:0]  mag;
        logic [1:0][PULL_W-1:0]  pull;
    } side_t;

endpackage

`default_nettype wire

>>> rtl/srd_sqrt.sv
// Pipelined integer square root, one result bit per stage, several lanes.
`timescale 1ns / 1ps
`default_nettype none

module srd_sqrt #(
    parameter int LANES  = 2,
    parameter int SIDE_W = 1
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   adv,
    input  wire logic                                   in_valid,
    input  wire logic [LANES-1:0][srd_pkg::SQ_W-1:0]    in_sq,
    input  wire logic [SIDE_W-1:0]                      in_side,
    output logic                                        out_valid,
    output logic [LANES-1:0][srd_pkg::ROOT_W-1:0]       out_root,
    output logic [SIDE_W-1:0]                           out_side
);

    localparam int STAGES = srd_pkg::ROOT_W;
    localparam int SQ_W   = srd_pkg::SQ_W;

    logic [STAGES-1:0]              valid_reg;
    logic [LANES-1:0][SQ_W-1:0]     n_reg     [STAGES];
    logic [LANES-1:0][SQ_W-1:0]     root_reg  [STAGES];
    logic [SIDE_W-1:0]              side_reg  [STAGES];
    logic [LANES-1:0][SQ_W-1:0]     n_next    [STAGES];
    logic [LANES-1:0][SQ_W-1:0]     root_next [STAGES];

    genvar k, l;
    generate
        for (k = 0; k < STAGES; k++) begin : g_stage
            for (l = 0; l < LANES; l++) begin : g_lane
                logic [SQ_W-1:0] n_src;
                logic [SQ_W-1:0] root_src;
                logic [SQ_W-1:0] trial;
                if (k == 0) begin : g_first
                    assign n_src    = in_sq[l];
                    assign root_src = '0;
                end
                else begin : g_rest
                    assign n_src    = n_reg[k-1][l];
                    assign root_src = root_reg[k-1][l];
                end
                assign trial = root_src + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
                always_comb
                begin
                    if (n_src >= trial)
                    begin
                        n_next[k][l]    = n_src - trial;
                        root_next[k][l] = (root_src >> 1) + (SQ_W'(1) << (SQ_W - 2 - 2 * k));
                    end
                    else
                    begin
                        n_next[k][l]    = n_src;
                        root_next[k][l] = root_src >> 1;
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    n_reg[k]    <= n_next[k];
                    root_reg[k] <= root_next[k];
                    side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[STAGES-2:0], in_valid};
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
            out_root[i] = root_reg[STAGES-1][i][srd_pkg::ROOT_W-1:0];
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/srd_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
`timescale 1ns / 1ps
`default_nettype none

module srd_div #(
    parameter int LANES  = 6,
    parameter int NUM_W  = 44,
    parameter int DEN_W  = 31,
    parameter int QW     = 15,
    parameter int SIDE_W = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          adv,
    input  wire logic                          in_valid,
    input  wire logic [LANES-1:0][NUM_W-1:0]   in_num,
    input  wire logic [LANES-1:0][DEN_W-1:0]   in_den,
    input  wire logic [SIDE_W-1:0]            in_side,
    output logic                               out_valid,
    output logic [LANES-1:0][QW-1:0]           out_quo,
    output logic [SIDE_W-1:0]                  out_side
);

    localparam int REM_W = DEN_W + QW;

    logic [QW-1:0]                  valid_reg;
    logic [LANES-1:0][REM_W-1:0]    rem_reg  [QW];
    logic [LANES-1:0][DEN_W-1:0]    den_reg  [QW];
    logic [LANES-1:0][QW-1:0]       quo_reg  [QW];
    logic [SIDE_W-1:0]              side_reg [QW];
    logic [LANES-1:0][REM_W-1:0]    rem_next [QW];
    logic [LANES-1:0][QW-1:0]       quo_next [QW];

    genvar k, l;
    generate
        for (k = 0; k < QW; k++) begin : g_stage
            for (l = 0; l < LANES; l++) begin : g_lane
                logic [REM_W-1:0] rem_src;
                logic [DEN_W-1:0] den_src;
                logic [QW-1:0]    quo_src;
                logic [REM_W-1:0] shifted;
                if (k == 0) begin : g_first
                    assign rem_src = REM_W'(in_num[l]);
                    assign den_src = in_den[l];
                    assign quo_src = '0;
                end
                else begin : g_rest
                    assign rem_src = rem_reg[k-1][l];
                    assign den_src = den_reg[k-1][l];
                    assign quo_src = quo_reg[k-1][l];
                end
                assign shifted = REM_W'(den_src) << (QW - 1 - k);
                always_comb
                begin
                    if (rem_src >= shifted)
                    begin
                        rem_next[k][l] = rem_src - shifted;
                        quo_next[k][l] = {quo_src[QW-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next[k][l] = rem_src;
                        quo_next[k][l] = {quo_src[QW-2:0], 1'b0};
                    end
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    rem_reg[k]  <= rem_next[k];
                    quo_reg[k]  <= quo_next[k];
                    den_reg[k]  <= (k == 0) ? in_den : den_reg[(k == 0) ? 0 : k-1];
                    side_reg[k] <= (k == 0) ? in_side : side_reg[(k == 0) ? 0 : k-1];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (adv)
            valid_reg <= {valid_reg[QW-2:0], in_valid};
    end

    // The last remainder and divisor are not needed past the final stage.
    logic unused_tail;
    assign unused_tail = ^{rem_reg[QW-1], den_reg[QW-1]};

    assign out_valid = valid_reg[QW-1] | (unused_tail & 1'b0);
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule

`default_nettype wire

>>> rtl/stick_radial_deadzone_core.sv
// Top level: radial dead-zone normalization of two sticks and two triggers.
// Pipeline: stages A and B, the 16-stage square root, C and D, the bit-per-stage divider, E.
// Throughput: one report per cycle; the whole pipeline stalls only when the result is not taken.
// Reset: rst_n clears all valid bits and loads the register defaults (7849, 8689, 30).
`timescale 1ns / 1ps
`default_nettype none

module stick_radial_deadzone_core #(
    parameter int FRAC_BITS = 14
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // left_x, left_y, right_x, right_y, left_pull, right_pull
    input  wire logic [srd_pkg::IN_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // left_out_x, left_out_y, right_out_x, right_out_y, left_pull_out,
    // right_pull_out, two zero pad bits
    output logic [srd_pkg::OUT_W-1:0]           m_tdata,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [srd_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [srd_pkg::DATA_W-1:0]     pwdata,
    output logic [srd_pkg::DATA_W-1:0]          prdata,
    output logic                                pready
);

    localparam int AXIS_W = srd_pkg::AXIS_W;
    localparam int PULL_W = srd_pkg::PULL_W;
    localparam int DZ_W   = srd_pkg::DZ_W;
    localparam int SQ_W   = srd_pkg::SQ_W;
    localparam int ROOT_W = srd_pkg::ROOT_W;
    localparam int PROD_W = srd_pkg::PROD_W;
    localparam int DEN_W  = srd_pkg::DEN_W;
    localparam int NUM_W  = PROD_W + FRAC_BITS;
    localparam int QW     = FRAC_BITS + 1;

    // Configuration registers.
    logic [DZ_W-1:0]   left_dz_reg;
    logic [DZ_W-1:0]   right_dz_reg;
    logic [PULL_W-1:0] thresh_reg;
    srd_pkg::reg_index_t wr_index;

    assign pready   = 1'b1;
    assign wr_index = srd_pkg::reg_index_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_dz_reg  <= srd_pkg::LEFT_DZ_RESET;
            right_dz_reg <= srd_pkg::RIGHT_DZ_RESET;
            thresh_reg   <= srd_pkg::THRESH_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (wr_index)
                srd_pkg::REG_LEFT_DZ:  left_dz_reg  <= pwdata[DZ_W-1:0];
                srd_pkg::REG_RIGHT_DZ: right_dz_reg <= pwdata[DZ_W-1:0];
                srd_pkg::REG_THRESH:   thresh_reg   <= pwdata[PULL_W-1:0];
                default:               ;
            endcase
        end
    end

    always_comb
    begin
        unique case (wr_index)
            srd_pkg::REG_LEFT_DZ:  prdata = {17'b0, left_dz_reg};
            srd_pkg::REG_RIGHT_DZ: prdata = {17'b0, right_dz_reg};
            srd_pkg::REG_THRESH:   prdata = {24'b0, thresh_reg};
            default:               prdata = '0;
        endcase
    end

    // The whole pipeline moves together whenever the output slot is free or being emptied.
    logic adv;
    logic e_valid_reg;
    assign adv      = !e_valid_reg || m_tready;
    assign s_tready = adv;

    // Stage A: axis magnitudes squared.
    logic [3:0][AXIS_W-1:0] in_axis;
    srd_pkg::side_t         a_side_next;
    logic                   a_valid_reg;
    logic [3:0][SQ_W-1:0]   a_sq_reg;
    srd_pkg::side_t         a_side_reg;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            in_axis[i]          = s_tdata[i*AXIS_W +: AXIS_W];
            a_side_next.neg[i]  = in_axis[i][AXIS_W-1];
            a_side_next.mag[i]  = in_axis[i][AXIS_W-1] ? (~in_axis[i] + 1'b1) : in_axis[i];
        end
        a_side_next.pull[0] = s_tdata[64 +: PULL_W];
        a_side_next.pull[1] = s_tdata[72 +: PULL_W];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 4; i++)
                a_sq_reg[i] <= a_side_next.mag[i] * a_side_next.mag[i];
            a_side_reg <= a_side_next;
        end
    end

    // Stage B: squared vector length per stick.
    logic                 b_valid_reg;
    logic [1:0][SQ_W-1:0] b_sum_reg;
    srd_pkg::side_t       b_side_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            b_sum_reg[0] <= a_sq_reg[0] + a_sq_reg[1];
            b_sum_reg[1] <= a_sq_reg[2] + a_sq_reg[3];
            b_side_reg   <= a_side_reg;
        end
    end

    logic                   sq_valid;
    logic [1:0][ROOT_W-1:0] sq_root;
    srd_pkg::side_t         sq_side;

    srd_sqrt #(
        .LANES  (2),
        .SIDE_W ($bits(srd_pkg::side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (b_valid_reg),
        .in_sq     (b_sum_reg),
        .in_side   (b_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // Stage C: clamp the length and compare against the dead zone.
    logic [1:0][DZ_W-1:0]   dz;
    logic [1:0][DZ_W-1:0]   clamp_len;
    logic                   c_valid_reg;
    logic [1:0][ROOT_W-1:0] c_root_reg;
    logic [1:0]             c_dead_reg;
    logic [1:0][DZ_W-1:0]   c_span_reg;
    srd_pkg::side_t         c_side_reg;

    assign dz[0] = left_dz_reg;
    assign dz[1] = right_dz_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
            clamp_len[s] = (sq_root[s] > ROOT_W'(srd_pkg::STICK_MAX)) ? srd_pkg::STICK_MAX
                                                                      : sq_root[s][DZ_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int s = 0; s < 2; s++)
            begin
                c_root_reg[s] <= sq_root[s];
                c_dead_reg[s] <= clamp_len[s] <= dz[s];
                c_span_reg[s] <= clamp_len[s] - dz[s];
            end
            c_side_reg <= sq_side;
        end
    end

    // Stage D: numerators and divisors. A dead stick or an idle trigger divides zero by one.
    logic [1:0][DZ_W-1:0]    dspan;
    logic [3:0][PROD_W:0]    axis_prod;
    logic [1:0][DEN_W-1:0]   stick_den;
    logic [5:0][NUM_W-1:0]   d_num_next;
    logic [5:0][DEN_W-1:0]   d_den_next;
    logic                    d_valid_reg;
    logic [5:0][NUM_W-1:0]   d_num_reg;
    logic [5:0][DEN_W-1:0]   d_den_reg;
    logic [3:0]              d_neg_reg;

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            dspan[s]     = srd_pkg::STICK_MAX - dz[s];
            stick_den[s] = c_root_reg[s] * dspan[s];
        end
        for (int i = 0; i < 4; i++)
        begin
            axis_prod[i]  = c_side_reg.mag[i] * c_span_reg[i/2];
            d_num_next[i] = c_dead_reg[i/2] ? '0
                                            : {axis_prod[i][PROD_W-1:0], FRAC_BITS'(0)};
            d_den_next[i] = c_dead_reg[i/2] ? DEN_W'(1) : stick_den[i/2];
        end
        for (int t = 0; t < 2; t++)
        begin
            d_num_next[4+t] = (c_side_reg.pull[t] > thresh_reg)
                ? NUM_W'({c_side_reg.pull[t] - thresh_reg, FRAC_BITS'(0)}) : '0;
            d_den_next[4+t] = (c_side_reg.pull[t] > thresh_reg)
                ? DEN_W'(srd_pkg::PULL_MAX - thresh_reg) : DEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_num_reg <= d_num_next;
            d_den_reg <= d_den_next;
            d_neg_reg <= c_side_reg.neg;
        end
    end

    logic                dv_valid;
    logic [5:0][QW-1:0]  dv_quo;
    logic [3:0]          dv_neg;

    srd_div #(
        .LANES  (6),
        .NUM_W  (NUM_W),
        .DEN_W  (DEN_W),
        .QW     (QW),
        .SIDE_W (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (d_valid_reg),
        .in_num    (d_num_reg),
        .in_den    (d_den_reg),
        .in_side   (d_neg_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_side  (dv_neg)
    );

    // Stage E: apply signs, cut to field widths, hold until taken.
    logic [5:0][QW+AXIS_W-1:0] quo_ext;
    logic [srd_pkg::OUT_W-1:0] e_data_next;
    logic [srd_pkg::OUT_W-1:0] e_data_reg;

    always_comb
    begin
        e_data_next = '0;
        for (int i = 0; i < 6; i++)
            quo_ext[i] = {{AXIS_W{1'b0}}, dv_quo[i]};
        for (int i = 0; i < 4; i++)
            e_data_next[i*AXIS_W +: AXIS_W] = dv_neg[i] ? (~quo_ext[i][AXIS_W-1:0] + 1'b1)
                                                        : quo_ext[i][AXIS_W-1:0];
        e_data_next[64 +: srd_pkg::PULL_OUT_W] = quo_ext[4][srd_pkg::PULL_OUT_W-1:0];
        e_data_next[79 +: srd_pkg::PULL_OUT_W] = quo_ext[5][srd_pkg::PULL_OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            e_data_reg <= e_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= s_tvalid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= sq_valid;
            d_valid_reg <= c_valid_reg;
            e_valid_reg <= dv_valid;
        end
    end

    // Stage C valid is carried in step with its data; stage D reads it.
    assign m_tvalid = e_valid_reg;
    assign m_tdata  = e_data_reg;

endmodule

`default_nettype wire

>>> rtl/srd_checker.sv
// Port-level checker for the stick dead-zone block and its bind.
`timescale 1ns / 1ps
`default_nettype none

module srd_checker (
    input wire logic                         clk,
    input wire logic                         rst_n,
    input wire logic                         s_tready,
    input wire logic                         m_tvalid,
    input wire logic                         m_tready,
    input wire logic [srd_pkg::OUT_W-1:0]    m_tdata
);

    // A waiting result keeps its transfer offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // The input side stalls exactly when a result is held back.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[95:94] == 2'b00)
        else $error("pad bits of result not zero");

endmodule

bind stick_radial_deadzone_core srd_checker u_srd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

>>> bench/tb_stick_radial_deadzone_core.sv
// Self-checking bench for the radial dead-zone stick block, with random stream stalls.
`timescale 1ns / 1ps
`default_nettype none

module tb_stick_radial_deadzone_core;

    localparam int FRAC = 14;

    typedef struct packed {
        logic [14:0] rpull;
        logic [14:0] lpull;
        logic [15:0] ry;
        logic [15:0] rx;
        logic [15:0] ly;
        logic [15:0] lx;
    } report_out_t;

    class deadzone_scoreboard;
        report_out_t pending[$];
        int unsigned errors;
        logic [14:0] ldz, rdz;
        logic [7:0] thr;

        function new();
            errors = 0;
            ldz = srd_pkg::LEFT_DZ_RESET;
            rdz = srd_pkg::RIGHT_DZ_RESET;
            thr = srd_pkg::THRESH_RESET;
        endfunction

        function longint unsigned int_root(longint unsigned n);
            longint unsigned root, bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > n) bitv >>= 2;
            while (bitv != 0)
            begin
                if (n >= root + bitv)
                begin
                    n -= root + bitv;
                    root = (root >> 1) + bitv;
                end
                else
                    root >>= 1;
                bitv >>= 2;
            end
            return root;
        endfunction

        function logic [15:0] scale_axis(longint a, longint unsigned span,
                                         longint unsigned den);
            longint unsigned mag, q;
            mag = (a < 0) ? -a : a;
            q = ((mag * span) << FRAC) / den;
            if (a < 0) q = -q;
            return q[15:0];
        endfunction

        function void stick(logic [15:0] rx, logic [15:0] ry, logic [14:0] dz,
                            output logic [15:0] ox, output logic [15:0] oy);
            longint x, y;
            longint unsigned r, m;
            x = $signed(rx);
            y = $signed(ry);
            r = int_root(x * x + y * y);
            m = (r > 32767) ? 32767 : r;
            ox = 0;
            oy = 0;
            if (m > dz)
            begin
                ox = scale_axis(x, m - dz, r * (32767 - dz));
                oy = scale_axis(y, m - dz, r * (32767 - dz));
            end
        endfunction

        function logic [14:0] trigger(logic [7:0] v);
            longint unsigned q;
            if (v <= thr) return 0;
            q = ((v - thr) << FRAC) / (255 - thr);
            return q[14:0];
        endfunction

        function void note_report(logic [79:0] d);
            report_out_t e;
            stick(d[15:0], d[31:16], ldz, e.lx, e.ly);
            stick(d[47:32], d[63:48], rdz, e.rx, e.ry);
            e.lpull = trigger(d[71:64]);
            e.rpull = trigger(d[79:72]);
            pending.push_back(e);
        endfunction

        function void check_result(logic [95:0] d);
            report_out_t e, a;
            a = d[93:0];
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10) $display("unexpected result %h", d);
                return;
            end
            e = pending.pop_front();
            if (a !== e || d[95:94] !== 2'b00)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %h got %h", e, d);
            end
        endfunction
    endclass

    logic clk = 0, rst_n = 0;
    logic s_tvalid = 0, m_tready = 0;
    logic s_tready, m_tvalid, pready;
    logic [79:0] s_tdata = '0;
    logic [95:0] m_tdata;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [srd_pkg::ADDR_W-1:0] paddr = '0;
    logic [srd_pkg::DATA_W-1:0] pwdata = '0;
    logic [srd_pkg::DATA_W-1:0] prdata;
    deadzone_scoreboard sb;
    bit calm;
    bit src_done;

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    stick_radial_deadzone_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready) sb.note_report(s_tdata);
        if (m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    task automatic write_reg(srd_pkg::reg_index_t idx, logic [31:0] v);
        @(negedge clk);
        psel = 1; pwrite = 1; penable = 0;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge clk);
        penable = 1;
        @(negedge clk);
        psel = 0; penable = 0; pwrite = 0;
        case (idx)
            srd_pkg::REG_LEFT_DZ:  sb.ldz = v[14:0];
            srd_pkg::REG_RIGHT_DZ: sb.rdz = v[14:0];
            srd_pkg::REG_THRESH:   sb.thr = v[7:0];
            default: ;
        endcase
    endtask

    function automatic logic [15:0] rand_axis();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(int'($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send(logic [79:0] d);
        int gap;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            repeat (gap) @(negedge clk);
        end
        s_tdata = d;
        s_tvalid = 1;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        s_tvalid = 0;
    endtask

    task automatic send_random(int n);
        for (int i = 0; i < n; i++)
        begin
            send({8'($urandom), 8'($urandom), rand_axis(), rand_axis(),
                  rand_axis(), rand_axis()});
        end
    endtask

    task automatic drain();
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    // Sink side: random stall bursts, none once the run is calm.
    initial
    begin
        int n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                m_tready = 0;
                n = $urandom_range(1, 14);
                repeat (n - 1) @(negedge clk);
            end
            else
                m_tready = 1;
        end
    end

    initial
    begin
        sb = new();
        calm = 0;
        repeat (5) @(negedge clk);
        rst_n = 1;
        // Directed reports at the field extremes.
        send({8'd0, 8'd255, 16'h0000, 16'h8000, 16'h0000, 16'h8000});
        send({8'd31, 8'd30, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000});
        send({8'd255, 8'd0, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF});
        send({8'd128, 8'd29, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
        send({8'd1, 8'd254, 16'h2000, 16'hE000, 16'h1EA9, 16'h0000});
        send({8'hAA, 8'h55, 16'hFFFF, 16'h0001, 16'h5555, 16'hAAAA});
        drain();
        // Zero dead zone, full dead zone and the threshold extremes.
        write_reg(srd_pkg::REG_LEFT_DZ, 0);
        write_reg(srd_pkg::REG_RIGHT_DZ, 32767);
        write_reg(srd_pkg::REG_THRESH, 255);
        write_reg(srd_pkg::REG_NONE, 32'h1234);
        send({8'd255, 8'd254, 16'h0000, 16'h8000, 16'h0000, 16'h8000});
        send({8'd1, 8'd0, 16'h0001, 16'h0000, 16'hFFFF, 16'h0000});
        send_random(60);
        drain();
        write_reg(srd_pkg::REG_LEFT_DZ, 32766);
        write_reg(srd_pkg::REG_RIGHT_DZ, 0);
        write_reg(srd_pkg::REG_THRESH, 0);
        send({8'd255, 8'd1, 16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF});
        send({8'd0, 8'd0, 16'h0001, 16'h0000, 16'h8000, 16'h0000});
        send_random(60);
        drain();
        write_reg(srd_pkg::REG_THRESH, 254);
        send({8'd255, 8'd254, 16'h0, 16'h0, 16'h0, 16'h0});
        send_random(40);
        drain();
        for (int p = 0; p < 5; p++)
        begin
            write_reg(srd_pkg::REG_LEFT_DZ, $urandom_range(0, 32766));
            write_reg(srd_pkg::REG_RIGHT_DZ, $urandom_range(0, 32766));
            write_reg(srd_pkg::REG_THRESH, $urandom_range(0, 254));
            if (p == 4) calm = 1;
            send_random(70);
            drain();
        end
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
rtl/srd_pkg.sv
rtl/srd_sqrt.sv
rtl/srd_div.sv
rtl/stick_radial_deadzone_core.sv
rtl/srd_checker.sv
bench/tb_stick_radial_deadzone_core.sv
